[hw/rtl/ravg_pkg.sv]
// Package for the ratiometric ADC averager: register map, fixed field widths,
// reset values and output limits. It depends on nothing else.
`timescale 1ns / 1ps

package ravg_pkg;

	// Fixed widths of configuration registers and result fields.
	localparam int COUNT_W = 7;
	localparam int REF_W   = 12;
	localparam int OUT_W   = 16;

	// Register port geometry.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [ADDR_W-1:0] ADDR_COUNT = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_REF   = 3'd4;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd10;
	localparam logic [REF_W-1:0]   REF_RESET   = 12'd1200;

	// Saturation value of every millivolt field.
	localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

endpackage

[hw/rtl/ravg_fifo.sv]
// Short queue between the accumulating front end and the conversion back end.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps

module ravg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;

	assign full  = (fill_q == CW'(DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

[hw/rtl/ravg_front.sv]
// Front end of the averager: accepts scans, keeps the running sums and the
// scan count, and queues a finished block of sums. Uses ravg_pkg.
`timescale 1ns / 1ps

module ravg_front #(
	parameter int SAMPLE_BITS = 12,
	parameter int SUM_W       = 18,
	parameter int CNT_W       = 7
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample_first,
	input  logic [SAMPLE_BITS-1:0] sample_second,
	input  logic [SAMPLE_BITS-1:0] sample_reference,
	input  logic [CNT_W-1:0]       scans_needed,
	input  logic [ravg_pkg::REF_W-1:0] ref_mv,
	input  logic                   queue_full,
	output logic                   push,
	output logic [CNT_W+ravg_pkg::REF_W+3*SUM_W-1:0] push_data
);

	logic [SUM_W-1:0] sum_first_q;
	logic [SUM_W-1:0] sum_second_q;
	logic [SUM_W-1:0] sum_ref_q;
	logic [CNT_W-1:0] scans_q;

	logic [SUM_W-1:0] sum_first_nx;
	logic [SUM_W-1:0] sum_second_nx;
	logic [SUM_W-1:0] sum_ref_nx;
	logic [CNT_W-1:0] scans_nx;
	logic             accept;
	logic             last_scan;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	assign sum_first_nx  = sum_first_q + SUM_W'(sample_first);
	assign sum_second_nx = sum_second_q + SUM_W'(sample_second);
	assign sum_ref_nx    = sum_ref_q + SUM_W'(sample_reference);
	assign scans_nx      = scans_q + 1'b1;

	// The block closes once the count reaches or passes the current setting.
	assign last_scan = (scans_nx >= scans_needed);
	assign push      = accept && last_scan;
	assign push_data = {scans_needed, ref_mv, sum_ref_nx, sum_second_nx, sum_first_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_first_q  <= '0;
			sum_second_q <= '0;
			sum_ref_q    <= '0;
			scans_q      <= '0;
		end else if (accept) begin
			if (last_scan) begin
				sum_first_q  <= '0;
				sum_second_q <= '0;
				sum_ref_q    <= '0;
				scans_q      <= '0;
			end else begin
				sum_first_q  <= sum_first_nx;
				sum_second_q <= sum_second_nx;
				sum_ref_q    <= sum_ref_nx;
				scans_q      <= scans_nx;
			end
		end
	end

endmodule

[hw/rtl/ravg_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Generic widths; no package dependency. The divisor must be nonzero.
`timescale 1ns / 1ps

module ravg_div #(
	parameter int NW = 30,
	parameter int DW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] numer,
	input  logic [DW-1:0] denom,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	assign trial    = {rem_q, num_q[NW-1]};
	assign diff     = trial - {1'b0, den_q};
	assign fits     = (trial >= {1'b0, den_q});
	assign done     = done_q;
	assign quotient = num_q;

	// Quotient bits shift into the bottom of the numerator register.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[hw/rtl/ravg_back.sv]
// Back end of the averager: takes a block of sums from the queue, runs up to six
// divisions on the shared divider and holds the result beat. Uses ravg_pkg
// and ravg_div.
`timescale 1ns / 1ps

module ravg_back #(
	parameter int SAMPLE_BITS = 12,
	parameter int SUM_W       = 18,
	parameter int CNT_W       = 7
) (
	input  logic clk,
	input  logic arst_n,
	input  logic queue_empty,
	input  logic [CNT_W+ravg_pkg::REF_W+3*SUM_W-1:0] queue_data,
	output logic queue_pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [ravg_pkg::OUT_W-1:0] first_millivolts,
	output logic [ravg_pkg::OUT_W-1:0] second_millivolts,
	output logic [ravg_pkg::OUT_W-1:0] supply_millivolts,
	output logic reference_zero
);

	localparam int REF_W = ravg_pkg::REF_W;
	localparam int OUT_W = ravg_pkg::OUT_W;
	localparam int NW    = SUM_W + REF_W;
	localparam int DW    = SUM_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [2:0] STEP_AVG_REF    = 3'd0;
	localparam logic [2:0] STEP_AVG_FIRST  = 3'd1;
	localparam logic [2:0] STEP_AVG_SECOND = 3'd2;
	localparam logic [2:0] STEP_MV_FIRST   = 3'd3;
	localparam logic [2:0] STEP_MV_SECOND  = 3'd4;
	localparam logic [2:0] STEP_MV_SUPPLY  = 3'd5;

	logic [1:0]       state_q;
	logic [2:0]       step_q;
	logic             zero_q;
	logic [SUM_W-1:0] sum_first_q;
	logic [SUM_W-1:0] sum_second_q;
	logic [SUM_W-1:0] sum_ref_q;
	logic [CNT_W-1:0] scans_q;
	logic [REF_W-1:0] ref_q;
	logic [SUM_W-1:0] avg_first_q;
	logic [SUM_W-1:0] avg_second_q;
	logic [SUM_W-1:0] avg_ref_q;
	logic [OUT_W-1:0] mv_first_q;
	logic [OUT_W-1:0] mv_second_q;
	logic [OUT_W-1:0] mv_supply_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_first_q;
	logic [OUT_W-1:0] out_second_q;
	logic [OUT_W-1:0] out_supply_q;
	logic             out_zero_q;

	logic             div_start;
	logic [NW-1:0]    div_numer;
	logic [DW-1:0]    div_denom;
	logic             div_done;
	logic [NW-1:0]    div_quot;
	logic [SUM_W-1:0] mul_a;
	logic [NW-1:0]    product;
	logic [OUT_W-1:0] quot_sat;
	logic             out_free;

	assign queue_pop = (state_q == ST_IDLE) && !queue_empty;
	assign div_start = (state_q == ST_ISSUE);
	assign out_free  = !out_valid_q || !out_stall;

	// One multiplier serves both channel conversions; the divider registers it.
	assign mul_a   = (step_q == STEP_MV_FIRST) ? avg_first_q : avg_second_q;
	assign product = NW'(mul_a) * NW'(ref_q);

	always_comb begin
		div_numer = NW'(sum_ref_q);
		div_denom = DW'(scans_q);
		case (step_q)
			STEP_AVG_REF: begin
				div_numer = NW'(sum_ref_q);
				div_denom = DW'(scans_q);
			end
			STEP_AVG_FIRST: begin
				div_numer = NW'(sum_first_q);
				div_denom = DW'(scans_q);
			end
			STEP_AVG_SECOND: begin
				div_numer = NW'(sum_second_q);
				div_denom = DW'(scans_q);
			end
			STEP_MV_FIRST, STEP_MV_SECOND: begin
				div_numer = product;
				div_denom = avg_ref_q;
			end
			STEP_MV_SUPPLY: begin
				div_numer = NW'({ref_q, {SAMPLE_BITS{1'b0}}});
				div_denom = avg_ref_q;
			end
			default: begin
				div_numer = NW'(sum_ref_q);
				div_denom = DW'(scans_q);
			end
		endcase
	end

	assign quot_sat = (div_quot > NW'(ravg_pkg::OUT_MAX)) ? ravg_pkg::OUT_MAX
		: div_quot[OUT_W-1:0];

	ravg_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.numer   (div_numer),
		.denom   (div_denom),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_ff @(posedge clk) begin
		if (queue_pop) begin
			{scans_q, ref_q, sum_ref_q, sum_second_q, sum_first_q} <= queue_data;
		end
		if ((state_q == ST_WAIT) && div_done) begin
			case (step_q)
				STEP_AVG_REF:    avg_ref_q    <= div_quot[SUM_W-1:0];
				STEP_AVG_FIRST:  avg_first_q  <= div_quot[SUM_W-1:0];
				STEP_AVG_SECOND: avg_second_q <= div_quot[SUM_W-1:0];
				STEP_MV_FIRST:   mv_first_q   <= quot_sat;
				STEP_MV_SECOND:  mv_second_q  <= quot_sat;
				STEP_MV_SUPPLY:  mv_supply_q  <= quot_sat;
				default:         avg_ref_q    <= avg_ref_q;
			endcase
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_first_q  <= zero_q ? ravg_pkg::OUT_MAX : mv_first_q;
			out_second_q <= zero_q ? ravg_pkg::OUT_MAX : mv_second_q;
			out_supply_q <= zero_q ? ravg_pkg::OUT_MAX : mv_supply_q;
			out_zero_q   <= zero_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_AVG_REF;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new beat replaces the old one in the cycle the old one leaves.
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						step_q  <= STEP_AVG_REF;
						zero_q  <= 1'b0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						if ((step_q == STEP_AVG_REF) && (div_quot == '0)) begin
							zero_q  <= 1'b1;
							state_q <= ST_EMIT;
						end else if (step_q == STEP_MV_SUPPLY) begin
							state_q <= ST_EMIT;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign first_millivolts  = out_first_q;
	assign second_millivolts = out_second_q;
	assign supply_millivolts = out_supply_q;
	assign reference_zero    = out_zero_q;

endmodule

[hw/rtl/ratiometric_adc_averager_unit.sv]
// Top level of the ratiometric ADC averager: register port, front end, queue
// and back end. Uses ravg_pkg, ravg_front, ravg_fifo and ravg_back.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake           | Beat contents
// ----------+-----------+---------------------+--------------------------------------------
// scan in   | input     | in_valid / in_stall | sample_first, sample_second, sample_reference
// result    | output    | out_valid/out_stall | first/second/supply_millivolts, reference_zero
// registers | input     | psel/penable/pready | average_count at 0x0, reference_millivolts at 0x4
//
// A scan that does not close an averaging block only adds to the running sums. A closing
// scan hands its sums to a two-entry queue; the back end then takes one block at a time
// and runs up to six divisions on one shared divider (a zero reference average ends the
// block after the first), which sets the result rate. Reset clears the sums, the scan
// count, the queue and the result beat, and loads the register reset values. in_stall
// rises only while the queue is full, and a result beat stalled at the output holds while
// the back end starts the next one.

module ratiometric_adc_averager_unit #(
	parameter int SAMPLE_BITS = 12,
	parameter int MAX_AVERAGE = 64
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ravg_pkg::ADDR_W-1:0]     paddr,
	input  logic [ravg_pkg::DATA_W-1:0]     pwdata,
	output logic [ravg_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample_first,
	input  logic [SAMPLE_BITS-1:0] sample_second,
	input  logic [SAMPLE_BITS-1:0] sample_reference,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ravg_pkg::OUT_W-1:0]   first_millivolts,
	output logic [ravg_pkg::OUT_W-1:0]   second_millivolts,
	output logic [ravg_pkg::OUT_W-1:0]   supply_millivolts,
	output logic                         reference_zero
);

	// A block never holds more than MAX_AVERAGE scans, so the sums cannot wrap.
	localparam int CNT_W   = $clog2(MAX_AVERAGE + 1);
	localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_AVERAGE);
	localparam int ENTRY_W = CNT_W + ravg_pkg::REF_W + 3 * SUM_W;

	logic [ravg_pkg::COUNT_W-1:0] count_q;
	logic [ravg_pkg::REF_W-1:0]   ref_q;

	logic               cfg_write;
	logic [CNT_W-1:0]   scans_needed;
	logic               queue_push;
	logic               queue_pop;
	logic               queue_full;
	logic               queue_empty;
	logic [ENTRY_W-1:0] queue_wdata;
	logic [ENTRY_W-1:0] queue_rdata;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ravg_pkg::COUNT_RESET;
			ref_q   <= ravg_pkg::REF_RESET;
		end else if (cfg_write) begin
			case (paddr)
				ravg_pkg::ADDR_COUNT: count_q <= pwdata[ravg_pkg::COUNT_W-1:0];
				ravg_pkg::ADDR_REF:   ref_q   <= pwdata[ravg_pkg::REF_W-1:0];
				default:              count_q <= count_q;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ravg_pkg::ADDR_COUNT: prdata = ravg_pkg::DATA_W'(count_q);
			ravg_pkg::ADDR_REF:   prdata = ravg_pkg::DATA_W'(ref_q);
			default:              prdata = '0;
		endcase
	end

	// A count of zero behaves as one, and counts above the limit are clamped.
	always_comb begin
		if (count_q == '0) begin
			scans_needed = CNT_W'(1);
		end else if (32'(count_q) > 32'(MAX_AVERAGE)) begin
			scans_needed = CNT_W'(MAX_AVERAGE);
		end else begin
			scans_needed = CNT_W'(count_q);
		end
	end

	ravg_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_W      (SUM_W),
		.CNT_W      (CNT_W)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample_first    (sample_first),
		.sample_second   (sample_second),
		.sample_reference(sample_reference),
		.scans_needed    (scans_needed),
		.ref_mv          (ref_q),
		.queue_full      (queue_full),
		.push            (queue_push),
		.push_data       (queue_wdata)
	);

	ravg_fifo #(
		.WIDTH(ENTRY_W),
		.DEPTH(2)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (queue_push),
		.wdata (queue_wdata),
		.pop   (queue_pop),
		.rdata (queue_rdata),
		.full  (queue_full),
		.empty (queue_empty)
	);

	ravg_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_W      (SUM_W),
		.CNT_W      (CNT_W)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.queue_empty      (queue_empty),
		.queue_data       (queue_rdata),
		.queue_pop        (queue_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.first_millivolts (first_millivolts),
		.second_millivolts(second_millivolts),
		.supply_millivolts(supply_millivolts),
		.reference_zero   (reference_zero)
	);

endmodule

[hw/rtl/ravg_checker.sv]
// Port-level checks for the ratiometric ADC averager, bound to the top level.
// Uses ravg_pkg for the result field width and saturation value.
`timescale 1ns / 1ps

module ravg_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [ravg_pkg::OUT_W-1:0] first_millivolts,
	input logic [ravg_pkg::OUT_W-1:0] second_millivolts,
	input logic [ravg_pkg::OUT_W-1:0] supply_millivolts,
	input logic                       reference_zero
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its contents.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(first_millivolts) && $stable(second_millivolts)
			&& $stable(supply_millivolts) && $stable(reference_zero))
		else $error("result beat changed while stalled");

	// A zero reference average forces all three voltages to full scale.
	a_zero_forces_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reference_zero |-> (first_millivolts == ravg_pkg::OUT_MAX)
			&& (second_millivolts == ravg_pkg::OUT_MAX)
			&& (supply_millivolts == ravg_pkg::OUT_MAX))
		else $error("zero reference result not saturated");

	// No result can be ready in the first cycle after reset is released.
	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result beat offered right after reset");

endmodule

bind ratiometric_adc_averager_unit ravg_checker u_ravg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.first_millivolts (first_millivolts),
	.second_millivolts(second_millivolts),
	.supply_millivolts(supply_millivolts),
	.reference_zero   (reference_zero)
);

[tb/ravg_reading_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the ratiometric ADC averager: follows register writes and scan beats,
// predicts each millivolt reading, and compares it with the result beats.
// Uses ravg_pkg. The testbench top instantiates it next to the unit.

module ravg_reading_checker #(
	parameter int SAMPLE_BITS = 12,
	parameter int MAX_AVERAGE = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [ravg_pkg::ADDR_W-1:0]     paddr,
	input  logic [ravg_pkg::DATA_W-1:0]     pwdata,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [SAMPLE_BITS-1:0]          sample_first,
	input  logic [SAMPLE_BITS-1:0]          sample_second,
	input  logic [SAMPLE_BITS-1:0]          sample_reference,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [ravg_pkg::OUT_W-1:0]      first_millivolts,
	input  logic [ravg_pkg::OUT_W-1:0]      second_millivolts,
	input  logic [ravg_pkg::OUT_W-1:0]      supply_millivolts,
	input  logic                            reference_zero,
	output int                              failures,
	output int                              pending
);

	typedef struct packed {
		logic [ravg_pkg::OUT_W-1:0] first_mv;
		logic [ravg_pkg::OUT_W-1:0] second_mv;
		logic [ravg_pkg::OUT_W-1:0] supply_mv;
		logic                       ref_zero;
	} reading_t;

	reading_t readings_due[$];

	logic [ravg_pkg::COUNT_W-1:0] scans_per_reading;
	logic [ravg_pkg::REF_W-1:0]   ref_mv;
	longint unsigned              sum_first;
	longint unsigned              sum_second;
	longint unsigned              sum_ref;
	int                           scans_taken;

	function automatic logic [ravg_pkg::OUT_W-1:0] clip_mv(input longint unsigned v);
		return (v > ravg_pkg::OUT_MAX) ? ravg_pkg::OUT_MAX : ravg_pkg::OUT_W'(v);
	endfunction

	// Adds one scan to the sums; a scan that closes the block queues its reading.
	task automatic accumulate_scan(input logic [SAMPLE_BITS-1:0] f,
			input logic [SAMPLE_BITS-1:0] s, input logic [SAMPLE_BITS-1:0] r);
		longint unsigned n;
		longint unsigned avg_f;
		longint unsigned avg_s;
		longint unsigned avg_r;
		longint unsigned full_scale;
		reading_t        rd;
		n = scans_per_reading;
		if (n == 0)
			n = 1;
		if (n > MAX_AVERAGE)
			n = MAX_AVERAGE;
		full_scale = 64'd1 << SAMPLE_BITS;
		sum_first += f;
		sum_second += s;
		sum_ref += r;
		scans_taken++;
		if (scans_taken >= n) begin
			avg_f = sum_first / n;
			avg_s = sum_second / n;
			avg_r = sum_ref / n;
			if (avg_r == 0) begin
				rd.first_mv = ravg_pkg::OUT_MAX;
				rd.second_mv = ravg_pkg::OUT_MAX;
				rd.supply_mv = ravg_pkg::OUT_MAX;
				rd.ref_zero = 1'b1;
			end else begin
				rd.first_mv = clip_mv(avg_f * ref_mv / avg_r);
				rd.second_mv = clip_mv(avg_s * ref_mv / avg_r);
				rd.supply_mv = clip_mv(full_scale * ref_mv / avg_r);
				rd.ref_zero = 1'b0;
			end
			readings_due.push_back(rd);
			sum_first = 0;
			sum_second = 0;
			sum_ref = 0;
			scans_taken = 0;
		end
	endtask

	task automatic check_field(input string field, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t due;
		if (!arst_n) begin
			readings_due.delete();
			scans_per_reading = ravg_pkg::COUNT_RESET;
			ref_mv = ravg_pkg::REF_RESET;
			sum_first = 0;
			sum_second = 0;
			sum_ref = 0;
			scans_taken = 0;
			failures = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ravg_pkg::ADDR_COUNT: scans_per_reading = pwdata[ravg_pkg::COUNT_W-1:0];
					ravg_pkg::ADDR_REF:   ref_mv = pwdata[ravg_pkg::REF_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					$error("result beat with no reading outstanding");
					failures++;
				end else begin
					due = readings_due.pop_front();
					check_field("first_millivolts", due.first_mv, first_millivolts);
					check_field("second_millivolts", due.second_mv, second_millivolts);
					check_field("supply_millivolts", due.supply_mv, supply_millivolts);
					check_field("reference_zero", due.ref_zero, reference_zero);
				end
			end
			if (in_valid && !in_stall)
				accumulate_scan(sample_first, sample_second, sample_reference);
			pending = readings_due.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the ratiometric_adc_averager_unit testbench: clock, reset, register writes,
// scan stimulus with random gaps and stalls, and the final verdict.
// Uses ravg_pkg and the scoreboard in ravg_reading_checker.sv.

module testbench;

	localparam int SAMPLE_BITS = 12;
	localparam int MAX_AVERAGE = 64;

	// Margin that covers the back end's work on one reading.
	localparam int DRAIN_CYCLES = 250;
	// Several times the slowest correct run, stalls and gaps included.
	localparam int CYCLE_LIMIT = 2_000_000;

	localparam int RANDOM_PHASES   = 15;
	localparam int SCANS_PER_PHASE = 97;

	localparam logic [SAMPLE_BITS-1:0]        CODE_MAX = '1;
	localparam logic [SAMPLE_BITS-1:0]        CODE_MID = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [SAMPLE_BITS-1:0]        CODE_ONE = SAMPLE_BITS'(1);
	localparam logic [ravg_pkg::DATA_W-1:0]   REF_MAX  = (1 << ravg_pkg::REF_W) - 1;

	logic clk;
	logic arst_n;

	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [ravg_pkg::ADDR_W-1:0] paddr;
	logic [ravg_pkg::DATA_W-1:0] pwdata;
	logic [ravg_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	logic                   in_valid;
	logic                   in_stall;
	logic [SAMPLE_BITS-1:0] sample_first;
	logic [SAMPLE_BITS-1:0] sample_second;
	logic [SAMPLE_BITS-1:0] sample_reference;

	logic                       out_valid;
	logic                       out_stall;
	logic [ravg_pkg::OUT_W-1:0] first_millivolts;
	logic [ravg_pkg::OUT_W-1:0] second_millivolts;
	logic [ravg_pkg::OUT_W-1:0] supply_millivolts;
	logic                       reference_zero;

	int failures;
	int pending;

	// Chance in percent that the sender leaves a cycle empty, and that the
	// receiver holds off a result beat.
	int gap_pct;
	int stall_pct;
	int cycle_count = 0;

	ratiometric_adc_averager_unit #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_AVERAGE(MAX_AVERAGE)
	) i_dut (.*);

	ravg_reading_checker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_AVERAGE(MAX_AVERAGE)
	) i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The receiver decides at each falling edge whether to stall the next edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog: a hung handshake or a reading that never arrives ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[ratiometric_adc_averager_unit] ERROR");
			$finish;
		end
	end

	// Mostly plain codes, with the rails showing up often enough to matter.
	function automatic logic [SAMPLE_BITS-1:0] pick_code();
		case ($urandom_range(7))
			0: return '0;
			1: return CODE_MAX;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Reference codes sit near what a 1.2 V reference gives at a 3.3 V supply.
	// Tiny codes drive the average to zero or the quotients into saturation.
	function automatic logic [SAMPLE_BITS-1:0] pick_reference();
		case ($urandom_range(7))
			0: return SAMPLE_BITS'($urandom_range(3));
			1: return SAMPLE_BITS'($urandom);
			default: return SAMPLE_BITS'($urandom_range(1700, 1300));
		endcase
	endfunction

	// Random upper bits above a register's width must be dropped by the unit.
	function automatic logic [ravg_pkg::DATA_W-1:0] pad_random(
			input logic [ravg_pkg::DATA_W-1:0] v, input int w);
		return (ravg_pkg::DATA_W'($urandom) << w) | v;
	endfunction

	// Called and returns at a falling edge. Valid stays high from one beat to
	// the next unless a gap is drawn, so it is assigned once per falling edge.
	task automatic send_scan(input logic [SAMPLE_BITS-1:0] f, input logic [SAMPLE_BITS-1:0] s,
			input logic [SAMPLE_BITS-1:0] r);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_first <= f;
		sample_second <= s;
		sample_reference <= r;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stops the sender until every reading predicted so far has come out, then
	// lets the back end settle so that the unit is idle.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Register writes only go out on an idle unit: setup cycle, then access cycle.
	task automatic write_reg(input logic [ravg_pkg::ADDR_W-1:0] addr,
			input logic [ravg_pkg::DATA_W-1:0] value);
		quiesce();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int count;
		int ref_setting;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample_first = '0;
		sample_second = '0;
		sample_reference = '0;
		gap_pct = 0;
		stall_pct = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with light sender gaps and heavy receiver stalls so
		// that the two-entry queue fills up early.
		gap_pct = 25;
		stall_pct = 63;

		// Reset settings: ten full-scale scans give 1200 mV on the first
		// channel and on the supply, and nothing on the second channel.
		repeat (10) send_scan(CODE_MAX, '0, CODE_MAX);

		// A count of zero behaves as one: every scan makes a reading. This
		// covers a zero reference, saturation from a reference of one code,
		// and the smallest nonzero channel code.
		write_reg(ravg_pkg::ADDR_COUNT, '0);
		send_scan('0, '0, '0);
		send_scan(CODE_MAX, CODE_MAX, '0);
		send_scan(CODE_MAX, CODE_MAX, CODE_ONE);
		send_scan(CODE_ONE, CODE_MAX, CODE_MAX);

		// A reference of 0 mV scales everything down to zero.
		write_reg(ravg_pkg::ADDR_COUNT, 1);
		write_reg(ravg_pkg::ADDR_REF, '0);
		send_scan(CODE_MAX, CODE_MAX, CODE_MAX);

		// The largest reference voltage, against full-scale and mid-scale codes.
		write_reg(ravg_pkg::ADDR_REF, REF_MAX);
		send_scan(CODE_MAX, CODE_MID, CODE_MAX);
		send_scan(CODE_MAX, CODE_MAX, CODE_MID);

		// Count lowered below the scans already taken: the next scan closes the
		// block and the sums are divided by the new count.
		write_reg(ravg_pkg::ADDR_REF, ravg_pkg::DATA_W'(ravg_pkg::REF_RESET));
		write_reg(ravg_pkg::ADDR_COUNT, ravg_pkg::DATA_W'(ravg_pkg::COUNT_RESET));
		repeat (4) send_scan(pick_code(), pick_code(), CODE_ONE);
		write_reg(ravg_pkg::ADDR_COUNT, 3);
		send_scan(pick_code(), pick_code(), '0);

		// Random part. Each phase starts with new settings on a drained unit;
		// leftover partial sums carry into the next phase, as they would in use.
		// First third: sender idles lightly, receiver heavily; second third the
		// other way round; last third runs at full rate on both sides.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p / 5)
				0: begin
					gap_pct = 25;
					stall_pct = 63;
				end
				1: begin
					gap_pct = 63;
					stall_pct = 25;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase

			// Counts span zero, one, the ceiling and a value past it, with
			// most phases on short blocks so that readings stay frequent.
			case (p % 5)
				0: count = $urandom_range(4, 1);
				1: count = $urandom_range(16, 5);
				2: begin
					if (p == 2)
						count = (1 << ravg_pkg::COUNT_W) - 1;
					else if (p == 7)
						count = MAX_AVERAGE;
					else
						count = $urandom_range(MAX_AVERAGE, 17);
				end
				3: count = (p == 3) ? 0 : 1;
				default: count = $urandom_range(8, 2);
			endcase

			if (p == 0)
				ref_setting = REF_MAX;
			else if (p == 3)
				ref_setting = 0;
			else
				ref_setting = $urandom_range(REF_MAX, 1);

			write_reg(ravg_pkg::ADDR_COUNT, pad_random(count, ravg_pkg::COUNT_W));
			write_reg(ravg_pkg::ADDR_REF, pad_random(ref_setting, ravg_pkg::REF_W));

			repeat (SCANS_PER_PHASE)
				send_scan(pick_code(), pick_code(), pick_reference());
		end

		quiesce();

		if (failures == 0)
			$display("[ratiometric_adc_averager_unit] OK");
		else
			$display("[ratiometric_adc_averager_unit] ERROR");
		$finish;
	end

endmodule
